// ===== sv/gcc_pkg.sv =====
`timescale 1ns / 1ps
package gcc_pkg;

  localparam int MAX_COINS = 7;
  localparam int AMT_W     = 24;
  localparam int COIN_W    = 16;
  localparam int IDX_W     = $clog2(MAX_COINS);
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = $clog2(AMT_W);
  localparam int OUT_W     = 48;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t CFG_COINS_IN_USE = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COIN_VALUE_0 = cfg_idx_t'(1);

  typedef struct packed {
    idx_t                                n;
    logic [MAX_COINS-1:0][COIN_W-1:0]    value;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_LD,
    S_SORT,
    S_SORT_END,
    S_GR_START,
    S_GR_WAIT,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

endpackage

// ===== sv/gcc_cfg.sv =====
`timescale 1ns / 1ps
module gcc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  gcc_pkg::cfg_idx_t                cfg_idx,
  input  logic [gcc_pkg::COIN_W-1:0]       cfg_wdata,
  output gcc_pkg::cfg_t                    cfg
);

  gcc_pkg::idx_t                                      coins_r;
  logic [gcc_pkg::MAX_COINS-1:0][gcc_pkg::COIN_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coins_r <= gcc_pkg::idx_t'(1);
      for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
        value_r[i] <= gcc_pkg::COIN_W'(1);
      end
    end else if (cfg_we) begin
      if (cfg_idx == gcc_pkg::CFG_COINS_IN_USE) begin
        coins_r <= cfg_wdata[gcc_pkg::IDX_W-1:0];
      end else begin
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
          if (cfg_idx == gcc_pkg::cfg_idx_t'(i + int'(gcc_pkg::CFG_COIN_VALUE_0))) begin
            value_r[i] <= cfg_wdata;
          end
        end
      end
    end
  end

  // zero coins means one
  always_comb begin
    cfg.n     = (coins_r == '0) ? gcc_pkg::idx_t'(1) : coins_r;
    cfg.value = value_r;
  end

endmodule

// ===== sv/gcc_div.sv =====
`timescale 1ns / 1ps
module gcc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gcc_pkg::AMT_W-1:0]   dividend,
  input  logic [gcc_pkg::COIN_W-1:0]  divisor,
  output logic                        done,
  output logic [gcc_pkg::AMT_W-1:0]   quotient,
  output logic [gcc_pkg::COIN_W-1:0]  remainder
);

  logic                        busy_r;
  logic                        done_r;
  gcc_pkg::step_t              step_r;
  logic [gcc_pkg::COIN_W-1:0]  dvs_r;
  logic [gcc_pkg::COIN_W-1:0]  part_r;
  logic [gcc_pkg::AMT_W-1:0]   quo_r;

  logic [gcc_pkg::COIN_W:0]    trial;
  logic [gcc_pkg::COIN_W:0]    diff;
  logic                        ge;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {part_r, quo_r[gcc_pkg::AMT_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == gcc_pkg::step_t'(gcc_pkg::AMT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r  <= divisor;
      part_r <= '0;
      quo_r  <= dividend;
      step_r <= '0;
    end else if (busy_r) begin
      part_r <= ge ? diff[gcc_pkg::COIN_W-1:0] : trial[gcc_pkg::COIN_W-1:0];
      quo_r  <= {quo_r[gcc_pkg::AMT_W-2:0], ge};
      step_r <= step_r + gcc_pkg::step_t'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = part_r;

endmodule

// ===== sv/greedy_coin_change.sv =====
`timescale 1ns / 1ps
// Greedy coin change.
// in_*  : one item per amount, in_tdata[23:0] = amount.
// out_* : one item per coin in use, lowest value first. out_tdata holds
//         slot, coin value and coin count; out_tuser marks that a remainder
//         was left over; out_tlast marks the final item of the amount.
// cfg_* : index 0 sets the number of coins in use (0 acts as 1), indexes
//         1 to 7 set the coin values. Write only while the block is idle.
// Per amount with n coins: a bubble sort of the coin values over one
// shared comparator, then one 24-step restoring division per nonzero
// coin on a single shared divider, then the result items in turn.
// in_tready is high only while idle; one amount is in work at a time.
// A stalled receiver holds the current result item in the output register
// and the block waits. Reset returns the block to idle, sets one coin in
// use and all coin values to 1.
module greedy_coin_change (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gcc_pkg::AMT_W-1:0]         in_tdata,   // [23:0] amount
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gcc_pkg::OUT_W-1:0]         out_tdata,  // [2:0] slot, [18:3] denomination,
                                                        // [42:19] coin_total, rest zero
  output logic                              out_tuser,  // [0] no_solution
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  gcc_pkg::cfg_idx_t                 cfg_idx,
  input  logic [gcc_pkg::COIN_W-1:0]        cfg_wdata
);

  gcc_pkg::cfg_t               cfg;
  gcc_pkg::state_t             state_r, state_nxt;

  logic [gcc_pkg::COIN_W-1:0]  v_r   [gcc_pkg::MAX_COINS];
  logic [gcc_pkg::AMT_W-1:0]   cnt_r [gcc_pkg::MAX_COINS];
  logic [gcc_pkg::COIN_W-1:0]  hold_r;
  logic [gcc_pkg::AMT_W-1:0]   rem_r;
  gcc_pkg::idx_t               k_r, m_r, a_r, slot_r, top_r;

  gcc_pkg::idx_t               rd_idx;
  logic [gcc_pkg::COIN_W-1:0]  v_rd;
  gcc_pkg::idx_t               k_prev;
  logic                        sort_lt;
  logic                        div_start;
  logic                        div_done;
  logic [gcc_pkg::AMT_W-1:0]   div_quo;
  logic [gcc_pkg::COIN_W-1:0]  div_rem;
  logic                        in_fire;

  logic                        out_tvalid_r;
  logic [gcc_pkg::OUT_W-1:0]   out_tdata_r;
  logic                        out_tuser_r;
  logic                        out_tlast_r;

  gcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gcc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (v_rd),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign v_rd    = v_r[rd_idx];
  assign k_prev  = k_r - gcc_pkg::idx_t'(1);
  assign sort_lt = (v_rd < hold_r);
  assign in_fire = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (cfg.n == gcc_pkg::idx_t'(1)) ? gcc_pkg::S_GR_START : gcc_pkg::S_SORT_LD;
        end
      end
      gcc_pkg::S_SORT_LD: state_nxt = gcc_pkg::S_SORT;
      gcc_pkg::S_SORT: begin
        if (k_r == m_r) state_nxt = gcc_pkg::S_SORT_END;
      end
      gcc_pkg::S_SORT_END: begin
        state_nxt = (m_r == gcc_pkg::idx_t'(1)) ? gcc_pkg::S_GR_START : gcc_pkg::S_SORT_LD;
      end
      gcc_pkg::S_GR_START: begin
        if (v_rd != '0) begin
          state_nxt = gcc_pkg::S_GR_WAIT;
        end else if (a_r == '0) begin
          state_nxt = gcc_pkg::S_OUT_LD;
        end
      end
      gcc_pkg::S_GR_WAIT: begin
        if (div_done) begin
          state_nxt = (a_r == '0) ? gcc_pkg::S_OUT_LD : gcc_pkg::S_GR_START;
        end
      end
      gcc_pkg::S_OUT_LD: state_nxt = gcc_pkg::S_OUT_WAIT;
      gcc_pkg::S_OUT_WAIT: begin
        if (out_tready) begin
          state_nxt = out_tlast_r ? gcc_pkg::S_IDLE : gcc_pkg::S_OUT_LD;
        end
      end
      default: state_nxt = gcc_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    rd_idx    = '0;
    case (state_r)
      gcc_pkg::S_IDLE:     in_tready = 1'b1;
      gcc_pkg::S_SORT_LD:  rd_idx = '0;
      gcc_pkg::S_SORT:     rd_idx = k_r;
      gcc_pkg::S_SORT_END: rd_idx = m_r;
      gcc_pkg::S_GR_START: begin
        rd_idx    = a_r;
        div_start = (v_rd != '0);
      end
      gcc_pkg::S_GR_WAIT:  rd_idx = a_r;
      gcc_pkg::S_OUT_LD:   rd_idx = slot_r;
      gcc_pkg::S_OUT_WAIT: rd_idx = slot_r;
      default:             rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gcc_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gcc_pkg::S_OUT_LD) begin
        out_tvalid_r <= 1'b1;
      end else if (state_r == gcc_pkg::S_OUT_WAIT && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gcc_pkg::S_IDLE: begin
        if (in_fire) begin
          for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
            v_r[i] <= cfg.value[i];
          end
          m_r    <= cfg.n - gcc_pkg::idx_t'(1);
          a_r    <= cfg.n - gcc_pkg::idx_t'(1);
          top_r  <= cfg.n - gcc_pkg::idx_t'(1);
          rem_r  <= in_tdata;
          slot_r <= '0;
        end
      end
      gcc_pkg::S_SORT_LD: begin
        hold_r <= v_rd;
        k_r    <= gcc_pkg::idx_t'(1);
      end
      gcc_pkg::S_SORT: begin
        // carry the larger value up the row
        if (sort_lt) begin
          v_r[k_prev] <= v_rd;
        end else begin
          v_r[k_prev] <= hold_r;
          hold_r      <= v_rd;
        end
        k_r <= k_r + gcc_pkg::idx_t'(1);
      end
      gcc_pkg::S_SORT_END: begin
        v_r[m_r] <= hold_r;
        m_r      <= m_r - gcc_pkg::idx_t'(1);
      end
      gcc_pkg::S_GR_START: begin
        if (v_rd == '0) begin
          cnt_r[a_r] <= '0;
          if (a_r != '0) a_r <= a_r - gcc_pkg::idx_t'(1);
        end
      end
      gcc_pkg::S_GR_WAIT: begin
        if (div_done) begin
          cnt_r[a_r] <= div_quo;
          rem_r      <= {{(gcc_pkg::AMT_W-gcc_pkg::COIN_W){1'b0}}, div_rem};
          if (a_r != '0) a_r <= a_r - gcc_pkg::idx_t'(1);
        end
      end
      gcc_pkg::S_OUT_LD: begin
        out_tdata_r <= {{(gcc_pkg::OUT_W-gcc_pkg::AMT_W-gcc_pkg::COIN_W-gcc_pkg::IDX_W){1'b0}},
                        cnt_r[slot_r], v_rd, slot_r};
        out_tuser_r <= (rem_r != '0);
        out_tlast_r <= (slot_r == top_r);
      end
      gcc_pkg::S_OUT_WAIT: begin
        if (out_tready) slot_r <= slot_r + gcc_pkg::idx_t'(1);
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== sv/gcc_chk.sv =====
`timescale 1ns / 1ps
module gcc_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [gcc_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        out_tuser,
  input  logic                        out_tlast
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("block not busy after accepting an amount");

  a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after the last result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind greedy_coin_change gcc_chk u_gcc_chk (.*);
